// File: hw/rtl/m3mu_pkg.sv
`default_nettype none
package m3mu_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int DIM         = 3;
   localparam int CELLS       = DIM * DIM;
   localparam int IDX_W       = 4;
   localparam int CNT_W       = 2;
   localparam int KIND_W      = 3;
   localparam int PROD_W      = 2 * VALUE_WIDTH;
   localparam int ACC_W       = PROD_W + 2;

   typedef logic [KIND_W-1:0]             kind_type;
   typedef logic [IDX_W-1:0]              index_type;
   typedef logic [CNT_W-1:0]              count_type;
   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   localparam kind_type KIND_LOAD_A = 3'd0;
   localparam kind_type KIND_LOAD_B = 3'd1;
   localparam kind_type KIND_A_B    = 3'd2;
   localparam kind_type KIND_AT_B   = 3'd3;
   localparam kind_type KIND_A_V    = 3'd4;
   localparam kind_type KIND_AT_V   = 3'd5;
   localparam kind_type KIND_TRANS  = 3'd6;

   localparam count_type DIM_LAST = CNT_W'(DIM - 1);

   typedef struct packed {
      logic issue;
      logic first;
      logic last;
   } mac_ctl_type;

   function automatic index_type idx3(count_type row, count_type col);
      return index_type'(IDX_W'(row) * IDX_W'(DIM) + IDX_W'(col));
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/m3mu_mac.sv
`default_nettype none
module m3mu_mac (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire m3mu_pkg::mac_ctl_type ctl,
   input  wire m3mu_pkg::value_type   op_a,
   input  wire m3mu_pkg::value_type   op_b,
   output logic                       done,
   output m3mu_pkg::value_type        result
);
   import m3mu_pkg::*;

   mac_ctl_type               ctl_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic                      acc_last_ff;
   logic                      done_ff;
   value_type                 result_ff;
   value_type                 result_in;
   logic signed [ACC_W-1:0]   shifted;
   logic [ACC_W-VALUE_WIDTH:0] upper;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff      <= '0;
         acc_last_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         ctl_ff      <= ctl;
         acc_last_ff <= ctl_ff.issue && ctl_ff.last;
         done_ff     <= acc_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_a * op_b);
      if (ctl_ff.issue) begin
         if (ctl_ff.first) begin
            acc_ff <= ACC_W'(prod_ff);
         end else begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
      result_ff <= result_in;
   end

   always_comb begin
      shifted = acc_ff >>> FRAC_BITS;
      upper   = shifted[ACC_W-1:VALUE_WIDTH-1];
      if ((&upper) || !(|upper)) begin
         result_in = shifted[VALUE_WIDTH-1:0];
      end else if (shifted[ACC_W-1]) begin
         result_in = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      end else begin
         result_in = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule
`default_nettype wire

// File: hw/rtl/mat3_multiply_unit.sv
`default_nettype none
// 3x3 signed Q16.16 matrix unit. Load items write one element of A or B and leave the
// unit idle; kind 7 and loads with an index of 9 or more are dropped. Run items compute A*B,
// At*B, A*v, At*v (v is B's first three elements) or the transpose of A and return one
// element per result item in row-major order, last marked. The unit is busy (req_stall
// high) from a run's acceptance until its last element is taken. Each product element
// goes through one shared multiply-accumulate: three products issued in ST_MUL pass the
// product, accumulator and saturated result registers before ST_DRAIN captures the element,
// and the next one starts only after it is taken; a transpose element is read in ST_COPY.
module mat3_multiply_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire m3mu_pkg::kind_type   req_kind,
   input  wire m3mu_pkg::index_type  req_elem_index,
   input  wire m3mu_pkg::value_type  req_elem_value,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output m3mu_pkg::index_type       rsp_out_index,
   output m3mu_pkg::value_type       rsp_out_value,
   output logic                      rsp_last
);
   import m3mu_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DRAIN,
      ST_COPY,
      ST_SEND
   } state_type;

   state_type   state_ff;
   kind_type    op_ff;
   count_type   i_ff;
   count_type   j_ff;
   count_type   k_ff;
   logic        rsp_valid_ff;
   index_type   rsp_index_ff;
   value_type   rsp_value_ff;
   logic        rsp_last_ff;

   value_type   a_ff [CELLS];
   value_type   b_ff [CELLS];

   logic        accept;
   logic        is_vec;
   logic        is_trans_a;
   logic        elem_last;
   index_type   elem_index;
   index_type   a_addr;
   index_type   b_addr;
   value_type   a_rd;
   value_type   b_rd;
   mac_ctl_type mac_ctl;
   logic        mac_done;
   value_type   mac_result;

   assign accept     = req_valid && (state_ff == ST_IDLE);
   assign is_vec     = (op_ff == KIND_A_V) || (op_ff == KIND_AT_V);
   assign is_trans_a = (op_ff == KIND_AT_B) || (op_ff == KIND_AT_V);
   assign elem_last  = is_vec ? (i_ff == DIM_LAST) : ((i_ff == DIM_LAST) && (j_ff == DIM_LAST));
   assign elem_index = is_vec ? index_type'(i_ff) : idx3(i_ff, j_ff);

   always_comb begin
      priority if (state_ff == ST_COPY) begin
         a_addr = idx3(j_ff, i_ff);
      end else if (is_trans_a) begin
         a_addr = idx3(k_ff, i_ff);
      end else begin
         a_addr = idx3(i_ff, k_ff);
      end
      b_addr = is_vec ? index_type'(k_ff) : idx3(k_ff, j_ff);
      a_rd   = a_ff[a_addr];
      b_rd   = b_ff[b_addr];
   end

   always_comb begin
      mac_ctl.issue = (state_ff == ST_MUL);
      mac_ctl.first = (k_ff == '0);
      mac_ctl.last  = (k_ff == DIM_LAST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < CELLS; n++) begin
            a_ff[n] <= '0;
            b_ff[n] <= '0;
         end
      end else if (accept && (req_elem_index < index_type'(CELLS))) begin
         if (req_kind == KIND_LOAD_A) begin
            a_ff[req_elem_index] <= req_elem_value;
         end else if (req_kind == KIND_LOAD_B) begin
            b_ff[req_elem_index] <= req_elem_value;
         end
      end
   end

   m3mu_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .op_a   (a_rd),
      .op_b   (b_rd),
      .done   (mac_done),
      .result (mac_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         op_ff        <= KIND_LOAD_A;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               i_ff <= '0;
               j_ff <= '0;
               k_ff <= '0;
               if (accept) begin
                  op_ff <= req_kind;
                  if (req_kind == KIND_TRANS) begin
                     state_ff <= ST_COPY;
                  end else if ((req_kind == KIND_A_B) || (req_kind == KIND_AT_B) ||
                               (req_kind == KIND_A_V) || (req_kind == KIND_AT_V)) begin
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_MUL: begin
               if (k_ff == DIM_LAST) begin
                  k_ff     <= '0;
                  state_ff <= ST_DRAIN;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               if (mac_done) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= mac_result;
                  rsp_index_ff <= elem_index;
                  rsp_last_ff  <= elem_last;
                  state_ff     <= ST_SEND;
               end
            end
            ST_COPY: begin
               rsp_valid_ff <= 1'b1;
               rsp_value_ff <= a_rd;
               rsp_index_ff <= elem_index;
               rsp_last_ff  <= elem_last;
               state_ff     <= ST_SEND;
            end
            ST_SEND: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     if (is_vec || (j_ff == DIM_LAST)) begin
                        j_ff <= '0;
                        i_ff <= i_ff + 1'b1;
                     end else begin
                        j_ff <= j_ff + 1'b1;
                     end
                     state_ff <= (op_ff == KIND_TRANS) ? ST_COPY : ST_MUL;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

   a_valid_only_in_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_SEND))
      else $error("result shown outside send state");

   a_mac_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> (state_ff == ST_DRAIN))
      else $error("accumulator finished outside drain");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> !req_stall)
      else $error("unit still busy after last item taken");

   a_busy_until_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> req_stall)
      else $error("unit went idle before last item");

endmodule
`default_nettype wire

// File: tb/sv/tb_mat3_multiply_unit.sv
`timescale 1ns / 100ps

module tb_mat3_multiply_unit;
   import m3mu_pkg::*;

   localparam kind_type  KIND_UNUSED = 3'd7;
   localparam value_type VALUE_MAX   = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam value_type VALUE_MIN   = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam int        HOLD_CYCLES = 200;

   typedef struct packed {
      index_type index;
      value_type value;
      logic      last;
   } mat_elem_type;

   logic      clock = 1'b0;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   kind_type  req_kind;
   index_type req_elem_index;
   value_type req_elem_value;
   logic      rsp_valid;
   logic      rsp_stall;
   index_type rsp_out_index;
   value_type rsp_out_value;
   logic      rsp_last;

   value_type    shadow_a [CELLS];
   value_type    shadow_b [CELLS];
   mat_elem_type expected_elems [$];
   mat_elem_type want;
   int           mismatch_count = 0;
   int           hold_request   = 0;
   bit           idle_on        = 1'b1;

   mat3_multiply_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_elem_index (req_elem_index),
      .req_elem_value (req_elem_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_index  (rsp_out_index),
      .rsp_out_value  (rsp_out_value),
      .rsp_last       (rsp_last)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic value_type pick_value();
      case ($urandom_range(0, 7))
         0, 1: return value_type'($urandom);
         2: return VALUE_MAX;
         3: return VALUE_MIN;
         default: return value_type'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      endcase
   endfunction

   // exact sum of three products, floored by the fraction bits, then saturated
   function automatic value_type fixed_dot3(value_type x0, value_type x1, value_type x2,
                                            value_type y0, value_type y1, value_type y2);
      logic signed [ACC_W-1:0] sum;
      sum = x0 * y0 + x1 * y1 + x2 * y2;
      sum = sum >>> FRAC_BITS;
      if (sum > VALUE_MAX) return VALUE_MAX;
      if (sum < VALUE_MIN) return VALUE_MIN;
      return value_type'(sum);
   endfunction

   function automatic value_type a_elem(logic trans, int r, int c);
      return trans ? shadow_a[c*DIM + r] : shadow_a[r*DIM + c];
   endfunction

   task automatic push_elem(int index, value_type value, logic last);
      mat_elem_type e;
      e.index = index_type'(index);
      e.value = value;
      e.last  = last;
      expected_elems.push_back(e);
   endtask

   task automatic predict_matrix_result(kind_type kind, index_type idx, value_type value);
      logic trans;
      int   i, j;
      trans = (kind == KIND_AT_B) || (kind == KIND_AT_V);
      case (kind)
         KIND_LOAD_A: if (idx < CELLS) shadow_a[idx] = value;
         KIND_LOAD_B: if (idx < CELLS) shadow_b[idx] = value;
         KIND_A_B, KIND_AT_B: begin
            for (i = 0; i < DIM; i++)
               for (j = 0; j < DIM; j++)
                  push_elem(i*DIM + j,
                            fixed_dot3(a_elem(trans, i, 0), a_elem(trans, i, 1),
                                       a_elem(trans, i, 2), shadow_b[j],
                                       shadow_b[DIM + j], shadow_b[2*DIM + j]),
                            i*DIM + j == CELLS - 1);
         end
         KIND_A_V, KIND_AT_V: begin
            for (i = 0; i < DIM; i++)
               push_elem(i, fixed_dot3(a_elem(trans, i, 0), a_elem(trans, i, 1),
                                       a_elem(trans, i, 2), shadow_b[0], shadow_b[1],
                                       shadow_b[2]), i == DIM - 1);
         end
         KIND_TRANS: begin
            for (i = 0; i < DIM; i++)
               for (j = 0; j < DIM; j++)
                  push_elem(i*DIM + j, shadow_a[j*DIM + i], i*DIM + j == CELLS - 1);
         end
         default: ;
      endcase
   endtask

   // entered and left at a falling edge; valid stays high into the next call
   task automatic send_item(kind_type kind, index_type idx, value_type value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_elem_index <= idx;
      req_elem_value <= value;
      do @(posedge clock); while (req_stall);
      predict_matrix_result(kind, idx, value);
      @(negedge clock);
   endtask

   task automatic run_op(kind_type kind);
      send_item(kind, index_type'($urandom_range(0, 15)), value_type'($urandom));
   endtask

   task automatic idle_input();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic test_reset_values();
      run_op(KIND_A_B);
      run_op(KIND_A_V);
   endtask

   task automatic test_saturation();
      int i;
      for (i = 0; i < DIM; i++) send_item(KIND_LOAD_A, index_type'(i), VALUE_MIN);
      for (i = 0; i < DIM; i++) send_item(KIND_LOAD_B, index_type'(i*DIM), VALUE_MIN);
      run_op(KIND_A_B);
      run_op(KIND_A_V);
      for (i = 0; i < DIM; i++) send_item(KIND_LOAD_B, index_type'(i*DIM), VALUE_MAX);
      run_op(KIND_AT_B);
      run_op(KIND_AT_V);
   endtask

   task automatic test_ignored_items();
      send_item(KIND_LOAD_A, index_type'(CELLS), value_type'(32'h1234_5678));
      send_item(KIND_LOAD_B, '1, '1);
      send_item(KIND_UNUSED, index_type'(4), VALUE_MAX);
      run_op(KIND_TRANS);
   endtask

   task automatic test_rounding();
      send_item(KIND_LOAD_A, index_type'(4), value_type'(-1));
      send_item(KIND_LOAD_B, index_type'(4), value_type'(1));
      run_op(KIND_A_B);
      run_op(KIND_TRANS);
   endtask

   task automatic test_random_items(int count);
      int       n, r;
      kind_type kind;
      for (n = 0; n < count; n++) begin
         if (n % 45 == 0) idle_on = $urandom_range(0, 2) != 0;
         r = $urandom_range(0, 99);
         if (r < 2) begin
            run_op(KIND_UNUSED);
         end else if (r < 60) begin
            kind = $urandom_range(0, 1) ? KIND_LOAD_B : KIND_LOAD_A;
            send_item(kind, index_type'($urandom_range(0, 19) == 0 ? $urandom_range(9, 15)
                                                                  : $urandom_range(0, 8)),
                      pick_value());
         end else begin
            run_op(kind_type'($urandom_range(KIND_A_B, KIND_TRANS)));
         end
      end
      idle_on = 1'b1;
   endtask

   task automatic test_backpressure();
      idle_input();
      idle_on = 1'b0;
      @(posedge clock);
      hold_request = HOLD_CYCLES;
      @(negedge clock);
      run_op(KIND_A_B);
      send_item(KIND_LOAD_A, index_type'($urandom_range(0, 8)), pick_value());
      run_op(KIND_AT_V);
      send_item(KIND_LOAD_B, index_type'($urandom_range(0, 8)), pick_value());
      run_op(KIND_TRANS);
      idle_on = 1'b1;
   endtask

   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            stall_left = pick_gap();
            rsp_stall <= stall_left > 0;
            if (stall_left > 0) stall_left--;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_elems.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: index %0d value %h last %b",
                        rsp_out_index, rsp_out_value, rsp_last);
         end else begin
            want = expected_elems.pop_front();
            if (rsp_out_index !== want.index || rsp_out_value !== want.value ||
                rsp_last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: got index %0d value %h last %b, want index %0d value %h last %b",
                           rsp_out_index, rsp_out_value, rsp_last,
                           want.index, want.value, want.last);
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = KIND_LOAD_A;
      req_elem_index = '0;
      req_elem_value = '0;
      foreach (shadow_a[i]) begin
         shadow_a[i] = '0;
         shadow_b[i] = '0;
      end
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_saturation();
      test_ignored_items();
      test_rounding();
      test_random_items(240);
      test_backpressure();
      test_random_items(30);
      idle_input();
      while (expected_elems.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatch_count == 0 && expected_elems.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
